// ===== rtl/core/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int CNT_W     = 9;   // block count and free count
    localparam int ELEM_W    = 13;  // element size register
    localparam int IDXF_W    = 8;   // block index fields on the ports
    localparam int OFS_W     = 20;  // byte offset field
    localparam int STRIDE_W  = 14;  // block stride in bytes
    localparam int CFG_IDX_W = 1;

    localparam logic [ELEM_W-1:0] ELEM_RESET = 13'd8;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } pool_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]    block_count;
        logic [STRIDE_W-1:0] stride;
        logic                settled;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        logic [IDXF_W-1:0]   granted_index;
        logic [OFS_W-1:0]    granted_offset;
        logic [CNT_W-1:0]    free_blocks;
    } result_t;

endpackage

// ===== rtl/core/fixed_block_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Pool allocator for equal-sized blocks kept on a linked free list. Init
// links blocks 0..n-1 and clears all allocated marks; allocate pops the head
// and returns its index and data offset (3 words + index * stride); free
// pushes an allocated block back as the new head and flags any other free.
// Allocate, free and opcode three: the accept cycle reads the link memory,
// and the EXEC state writes it back and loads the output register, holding
// while that register is full; no new item is accepted until EXEC is left.
// Init sweeps the link memory, one write per entry, then reports. After
// reset a clearing pass over all MAX_BLOCKS entries runs with in_ready low,
// and a write of element_bytes holds in_ready low while the stride pipeline
// updates. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 256,
    parameter int WORD_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ELEM_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [IDXF_W-1:0]    block_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [IDXF_W-1:0]    granted_index,
    output logic [OFS_W-1:0]     granted_offset,
    output logic [CNT_W-1:0]     free_blocks
);

    cfg_t    cfg;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    fbfl_cfg #(
        .WORD_BYTES (WORD_BYTES)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg)
    );

    fbfl_pool #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BYTES (WORD_BYTES)
    ) u_pool (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .block_index (block_index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register parts the pool from the consumer
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign granted_index  = out_res_reg.granted_index;
    assign granted_offset = out_res_reg.granted_offset;
    assign free_blocks    = out_res_reg.free_blocks;

    // one item in flight: the cycle after an accept never accepts again
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("item accepted while previous item still in work");

    // an empty report means the count is zero and nothing was granted
    a_empty_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> free_blocks == '0 && granted_index == '0
    ) else $error("empty status with nonzero free count or grant");

    // free count never exceeds the pool size
    a_free_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(free_blocks) <= MAX_BLOCKS
    ) else $error("free count above pool size");

endmodule

// ===== rtl/core/fbfl_cfg.sv =====
// ----------------------------------------------------------------------------
// fbfl_cfg
// Configuration registers and the block stride pipeline
// (stride = word + element size rounded up to a whole word).
// ----------------------------------------------------------------------------
module fbfl_cfg
    import fbfl_pkg::*;
#(
    parameter int WORD_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ELEM_W-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    localparam int X_W     = ELEM_W + 1;
    localparam int SHIFT   = X_W + $clog2(WORD_BYTES);
    localparam int RECIP   = (2**SHIFT + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RECIP_W = X_W + 1;
    localparam int PROD_W  = X_W + RECIP_W;

    logic [CNT_W-1:0]    block_count_reg;
    logic [ELEM_W-1:0]   elem_reg;
    logic [1:0]          settle_reg;
    logic [1:0]          settle_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [X_W-1:0]      x_d_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [STRIDE_W-1:0] stride_next;

    logic [X_W-1:0] x;
    logic [X_W-1:0] quot;
    logic [X_W-1:0] qw;
    logic [X_W-1:0] rem;
    logic [X_W-1:0] rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
            elem_reg        <= ELEM_RESET;
            settle_reg      <= 2'd2;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write_en && cfg_index == REG_BLOCK_COUNT)
            begin
                block_count_reg <= cfg_wdata[CNT_W-1:0];
            end
            if (cfg_write_en && cfg_index == REG_ELEMENT_BYTES)
            begin
                elem_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        if (cfg_write_en && cfg_index == REG_ELEMENT_BYTES)
        begin
            settle_next = 2'd2;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // round up by reciprocal multiply, then one compare and fix-up
    assign x       = X_W'(elem_reg) + X_W'(WORD_BYTES - 1);
    assign quot    = X_W'(prod_reg >> SHIFT);
    assign qw      = X_W'(quot * X_W'(WORD_BYTES));
    assign rem     = x_d_reg - qw;
    assign rounded = (rem >= X_W'(WORD_BYTES)) ? qw + X_W'(WORD_BYTES) : qw;
    assign stride_next = STRIDE_W'(rounded + X_W'(WORD_BYTES));

    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_W'(x) * PROD_W'(RECIP);
        x_d_reg    <= x;
        stride_reg <= stride_next;
    end

    assign cfg.block_count = block_count_reg;
    assign cfg.stride      = stride_reg;
    assign cfg.settled     = (settle_reg == 2'd0);

endmodule

// ===== rtl/core/fbfl_pool.sv =====
// ----------------------------------------------------------------------------
// fbfl_pool
// Free list sequencer around the link memory: read on accept, modify and
// write back in the EXEC state, and a sweep for pool init and reset clearing.
// ----------------------------------------------------------------------------
module fbfl_pool
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 256,
    parameter int WORD_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [IDXF_W-1:0] block_index,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int WORD_W = IDX_W + 1;
    localparam int PROD_W = IDX_W + STRIDE_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BLOCKS - 1);

    // entry: {allocated mark, next link}
    logic [WORD_W-1:0] pool_mem [MAX_BLOCKS];
    logic [WORD_W-1:0] rd_reg;

    pool_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic              empty_reg, empty_next;
    logic [IDX_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              sweep_init_reg, sweep_init_next;

    opcode_t           op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_ok_reg;
    logic [CNT_W-1:0]  n_reg;

    opcode_t           op_in;
    logic              in_accept;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_mark;
    logic [IDX_W-1:0]  rd_link;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic [IDX_W-1:0]  sweep_link;
    logic [CNT_W-1:0]  n_sat;
    logic [PROD_W-1:0] ofs_prod;
    logic [PROD_W-1:0] ofs_sum;

    assign op_in     = opcode_t'(opcode);
    assign in_ready  = (state_reg == S_IDLE) && cfg.settled;
    assign in_accept = in_valid && in_ready;
    assign res_valid = (state_reg == S_EXEC);

    assign rd_addr = (op_in == OP_ALLOC) ? head_reg : IDX_W'(block_index);
    assign rd_mark = rd_reg[IDX_W];
    assign rd_link = rd_reg[IDX_W-1:0];

    assign n_sat = (32'(cfg.block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                       : cfg.block_count;

    // blocks are linked in order, the last one holds link 0
    assign sweep_link = ((32'(sweep_cnt_reg) + 32'd1) < 32'(n_reg))
                        ? IDX_W'(sweep_cnt_reg + 1'b1) : '0;

    assign ofs_prod = PROD_W'(head_reg) * PROD_W'(cfg.stride);
    assign ofs_sum  = ofs_prod + PROD_W'(3 * WORD_BYTES);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pool_mem[mem_wa] <= mem_wd;
        end
        if (in_accept)
        begin
            rd_reg <= pool_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= op_in;
            idx_reg    <= IDX_W'(block_index);
            idx_ok_reg <= (32'(block_index) < MAX_BLOCKS);
            n_reg      <= n_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            head_reg       <= '0;
            free_reg       <= '0;
            empty_reg      <= 1'b1;
            sweep_cnt_reg  <= '0;
            sweep_init_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            free_reg       <= free_next;
            empty_reg      <= empty_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_init_reg <= sweep_init_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        empty_next      = empty_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_init_next = sweep_init_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        res             = '0;
        res.status      = ST_OK;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we         = 1'b1;
                mem_wa         = sweep_cnt_reg;
                mem_wd         = {1'b0, sweep_link};
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == LAST)
                begin
                    sweep_cnt_next = '0;
                    state_next     = sweep_init_reg ? S_EXEC : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op_in == OP_INIT)
                    begin
                        state_next      = S_SWEEP;
                        sweep_init_next = 1'b1;
                        sweep_cnt_next  = '0;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_INIT:
                    begin
                        head_next  = '0;
                        free_next  = n_reg;
                        empty_next = (n_reg == '0);
                    end
                    OP_ALLOC:
                    begin
                        if (empty_reg || free_reg == '0)
                        begin
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_we             = res_ready;
                            mem_wa             = head_reg;
                            mem_wd             = {1'b1, rd_link};
                            head_next          = rd_link;
                            free_next          = free_reg - 1'b1;
                            empty_next         = (free_reg == CNT_W'(1));
                            res.granted_index  = IDXF_W'(head_reg);
                            res.granted_offset = OFS_W'(ofs_sum);
                        end
                    end
                    OP_FREE:
                    begin
                        if (!idx_ok_reg || !rd_mark)
                        begin
                            res.status = ST_NOT_ALLOC;
                        end
                        else
                        begin
                            mem_we     = res_ready;
                            mem_wa     = idx_reg;
                            mem_wd     = {1'b0, (empty_reg ? IDX_W'(0) : head_reg)};
                            head_next  = idx_reg;
                            free_next  = free_reg + 1'b1;
                            empty_next = 1'b0;
                        end
                    end
                    OP_NOP:
                    begin
                    end
                endcase
                res.free_blocks = free_next;
                // hold everything until the output register can take the item
                if (res_ready)
                begin
                    state_next      = S_IDLE;
                    sweep_init_next = 1'b0;
                end
                else
                begin
                    head_next  = head_reg;
                    free_next  = free_reg;
                    empty_next = empty_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/free_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_checker
// Watches the configuration, request and result ports of the free list
// allocator. Keeps its own copy of the pool (links, allocated marks, head,
// free count) and compares every result, field by field, in order.
// ----------------------------------------------------------------------------
module free_list_checker
    import fbfl_pkg::*;
#(
    parameter int POOL_BLOCKS = 256,
    parameter int WORD_BYTES  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ELEM_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [IDXF_W-1:0]    block_index,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    input  logic [IDXF_W-1:0]    granted_index,
    input  logic [OFS_W-1:0]     granted_offset,
    input  logic [CNT_W-1:0]     free_blocks,
    output int                   mismatches,
    output int                   outstanding
);

    logic [IDXF_W-1:0] link_mem [POOL_BLOCKS];
    bit                in_use   [POOL_BLOCKS];
    logic [IDXF_W-1:0] head;
    logic [CNT_W-1:0]  free_cnt;
    bit                list_empty;
    logic [CNT_W-1:0]  cfg_blocks;
    logic [ELEM_W-1:0] elem_size;
    result_t           pending_results[$];
    int                fail_count = 0;
    int                result_no  = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(string what);
        $display("ERROR %0t: %s", $time, what);
        fail_count++;
    endtask

    // applies one item to the pool copy and returns the result it should give
    function automatic result_t pool_step(opcode_t op, logic [IDXF_W-1:0] blk);
        result_t           res;
        int unsigned       n;
        int unsigned       stride;
        logic [IDXF_W-1:0] taken;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_INIT:
            begin
                n = (cfg_blocks > POOL_BLOCKS) ? POOL_BLOCKS : cfg_blocks;
                foreach (in_use[i])
                    in_use[i] = 1'b0;
                for (int i = 0; i < n; i++)
                    link_mem[i] = (i + 1 < n) ? IDXF_W'(i + 1) : IDXF_W'(0);
                head       = '0;
                free_cnt   = CNT_W'(n);
                list_empty = (n == 0);
            end
            OP_ALLOC:
            begin
                if (list_empty || free_cnt == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    taken         = head;
                    head          = link_mem[taken];
                    in_use[taken] = 1'b1;
                    free_cnt      = free_cnt - 1'b1;
                    list_empty    = (free_cnt == 0);
                    // block header plus element rounded up to a whole word
                    stride = WORD_BYTES
                           + ((elem_size + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
                    res.granted_index  = taken;
                    res.granted_offset = OFS_W'(3 * WORD_BYTES + taken * stride);
                end
            end
            OP_FREE:
            begin
                if (!in_use[blk])
                    res.status = ST_NOT_ALLOC;
                else
                begin
                    link_mem[blk] = list_empty ? IDXF_W'(0) : head;
                    head          = blk;
                    in_use[blk]   = 1'b0;
                    free_cnt      = free_cnt + 1'b1;
                    list_empty    = 1'b0;
                end
            end
            default:
                ;
        endcase
        res.free_blocks = free_cnt;
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      result_no, field, got, want));
    endtask

    task automatic check_result();
        result_t want;
        result_no++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none expected", result_no));
            return;
        end
        want = pending_results.pop_front();
        check_field("status", 32'(status), 32'(want.status));
        check_field("granted_index", 32'(granted_index), 32'(want.granted_index));
        check_field("granted_offset", 32'(granted_offset), 32'(want.granted_offset));
        check_field("free_blocks", 32'(free_blocks), 32'(want.free_blocks));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (in_use[i])
                in_use[i] = 1'b0;
            foreach (link_mem[i])
                link_mem[i] = '0;
            head       = '0;
            free_cnt   = '0;
            list_empty = 1'b1;
            cfg_blocks = '0;
            elem_size  = ELEM_RESET;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare first so a result never matches an item taken at the same edge
            if (out_valid && out_ready)
                check_result();
            if (cfg_write_en)
            begin
                if (cfg_index == REG_BLOCK_COUNT)
                    cfg_blocks = cfg_wdata[CNT_W-1:0];
                else if (cfg_index == REG_ELEMENT_BYTES)
                    elem_size = cfg_wdata;
            end
            if (in_valid && in_ready)
                pending_results.push_back(pool_step(opcode_t'(opcode), block_index));
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/fixed_block_free_list_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit_tb
// Drives init, allocate, free and no-op items through the allocator under
// several pool sizes and element sizes, with random idling on both channels.
// A directed opening covers empty pools, bad frees, saturated block counts
// and extreme element sizes; random phases then fill, drain and churn pools.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit_tb;
    import fbfl_pkg::*;

    localparam int POOL_BLOCKS   = 256;
    localparam int WORD_BYTES    = 8;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int GAP_PCT       = 21;
    localparam int SETTLE_CYCLES = POOL_BLOCKS + 8;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ELEM_W-1:0]    cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           opcode;
    logic [IDXF_W-1:0]    block_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic [IDXF_W-1:0]    granted_index;
    logic [OFS_W-1:0]     granted_offset;
    logic [CNT_W-1:0]     free_blocks;
    int                   mismatches;
    int                   outstanding;
    bit                   steady;
    logic [IDXF_W-1:0]    held_blocks[$];
    opcode_t              ops_in_flight[$];

    fixed_block_free_list_allocator_unit #(
        .MAX_BLOCKS (POOL_BLOCKS),
        .WORD_BYTES (WORD_BYTES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .free_blocks    (free_blocks)
    );

    free_list_checker #(
        .POOL_BLOCKS (POOL_BLOCKS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .free_blocks    (free_blocks),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= steady || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // blocks seen granted are candidates for well-formed frees
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && ops_in_flight.size() > 0)
        begin
            if (ops_in_flight.pop_front() == OP_ALLOC && status == ST_OK)
                held_blocks.push_back(granted_index);
        end
    end

    task automatic send(opcode_t op, logic [IDXF_W-1:0] blk);
        while (!steady && $urandom_range(99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        block_index <= blk;
        do
            @(posedge clk);
        while (!in_ready);
        ops_in_flight.push_back(op);
        if (op == OP_INIT)
            held_blocks.delete();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 20000);
    endtask

    task automatic set_pool(logic [CNT_W-1:0] count, logic [ELEM_W-1:0] ebytes);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_BLOCK_COUNT;
        cfg_wdata    <= ELEM_W'(count);
        @(posedge clk);
        cfg_index <= REG_ELEMENT_BYTES;
        cfg_wdata <= ebytes;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        held_blocks.delete();
    endtask

    initial
    begin
        int                produced;
        int                p_alloc;
        int                phase_len;
        int                pick;
        int                slot;
        bit                big;
        opcode_t           op;
        logic [IDXF_W-1:0] blk;
        logic [CNT_W-1:0]  count;
        logic [ELEM_W-1:0] ebytes;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_BLOCK_COUNT;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_NOP;
        block_index  <= '0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // nothing initialized yet: pool is empty and nothing is allocated
        send(OP_ALLOC, 8'h00);
        send(OP_FREE, 8'h00);
        send(OP_NOP, 8'hFF);
        drain();

        // three blocks, one-byte elements: fill, overflow, double free, reuse
        set_pool(9'd3, 13'd1);
        send(OP_INIT, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_FREE, 8'd1);
        send(OP_FREE, 8'd1);
        send(OP_FREE, 8'hFF);
        send(OP_ALLOC, 8'h00);
        send(OP_FREE, 8'd2);
        send(OP_FREE, 8'd0);
        send(OP_ALLOC, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_NOP, 8'h5A);
        drain();

        // zero-block pool
        set_pool(9'd0, 13'd4096);
        send(OP_INIT, 8'h00);
        send(OP_ALLOC, 8'h00);
        drain();

        // oversized block count saturates, zero element size
        set_pool(9'd511, 13'd0);
        send(OP_INIT, 8'h00);
        send(OP_ALLOC, 8'h00);
        send(OP_ALLOC, 8'h00);
        drain();

        produced = 0;
        big      = 1'b1;
        while (produced < RANDOM_ITEMS)
        begin
            if (big)
            begin
                count     = (produced == 0 || $urandom_range(1)) ? 9'd511 : 9'd256;
                ebytes    = (produced == 0 || $urandom_range(1)) ? 13'h1FFF : 13'd4096;
                phase_len = 520;
                p_alloc   = 75;
            end
            else
            begin
                case ($urandom_range(9))
                    0:       count = 9'd0;
                    1:       count = CNT_W'($urandom_range(17, 80));
                    default: count = CNT_W'($urandom_range(1, 16));
                endcase
                case ($urandom_range(5))
                    0:       ebytes = 13'd1;
                    1:       ebytes = 13'd4096;
                    2:       ebytes = 13'h1FFF;
                    3:       ebytes = 13'd0;
                    default: ebytes = ELEM_W'($urandom_range(1, 4096));
                endcase
                phase_len = $urandom_range(40, 120);
                p_alloc   = $urandom_range(35, 75);
            end
            // the first random phase runs with no idling on either side
            steady = (produced == 0);
            set_pool(count, ebytes);
            send(OP_INIT, IDXF_W'($urandom));
            produced++;
            repeat (phase_len)
            begin
                pick = $urandom_range(99);
                blk  = IDXF_W'($urandom);
                if (pick < p_alloc)
                    op = OP_ALLOC;
                else if (pick < 97)
                begin
                    op = OP_FREE;
                    if (pick < 94 && held_blocks.size() > 0)
                    begin
                        slot = $urandom_range(held_blocks.size() - 1);
                        blk  = held_blocks[slot];
                        held_blocks.delete(slot);
                    end
                end
                else if (pick < 99)
                    op = OP_NOP;
                else
                    op = OP_INIT;
                send(op, blk);
                if (op != OP_NOP)
                    produced++;
            end
            drain();
            big = ($urandom_range(7) == 0);
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
